[hw/rtl/ttpt_pkg.sv]
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared types and constants of the timed travel position tracker: request
// and motion codes, fixed field widths and the divider status bundle.
// ----------------------------------------------------------------------------
package ttpt_pkg;

    // Fixed field widths.
    localparam int REQ_W     = 3;
    localparam int ELAPSED_W = 32;
    localparam int TRAVEL_W  = 16;
    localparam int POS_W     = 23;

    // Elapsed time times 100 needs seven more bits.
    localparam int NUM_W     = ELAPSED_W + 7;

    // Travel time in microseconds: 16 bits times a 20-bit constant.
    localparam int US_W      = 20;
    localparam int DEN_W     = TRAVEL_W + US_W;
    localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;

    // The travel time is scaled to microseconds one 4-bit digit per cycle.
    localparam int DIGIT_W    = 4;
    localparam int DEN_DIGITS = TRAVEL_W / DIGIT_W;
    localparam int PROD_W     = US_W + DIGIT_W;

    // Travel time after reset, in seconds.
    localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = 16'd30;

    // Request codes; unused codes behave as a plain update.
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_OPEN   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_STOP   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd4;

    // Motion mode.
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_CLOSING = 2'd2
    } mode_t;

    // Status returned by the divider for one travel step.
    typedef struct packed {
        logic done;       // quotient is final (one-cycle pulse)
        logic saturated;  // quotient exceeded the quotient register
    } div_stat_t;

endpackage

[hw/rtl/ttpt_div.sv]
// ----------------------------------------------------------------------------
// ttpt_div
// Travel step divider. Computes floor(elapsed * 100 * 2^F / (travel * 1e6))
// digit-serially: the divisor is built one 4-bit digit of the travel time
// per cycle, then a restoring division shifts in one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ttpt_div
    import ttpt_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ELAPSED_W-1:0]       elapsed,
    input  logic [TRAVEL_W-1:0]        travel,
    output logic [FRACTION_BITS+6:0]   quotient,
    output div_stat_t                  stat
);

    localparam int QW    = FRACTION_BITS + 7;
    localparam int STEPS = NUM_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DIG_CNT_W = $clog2(DEN_DIGITS);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_DEN  = 3'b010,
        D_DIV  = 3'b100
    } dstate_t;

    dstate_t              state_reg, state_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [TRAVEL_W-1:0]  travel_reg, travel_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [QW-1:0]        q_reg, q_next;
    logic                 sat_reg, sat_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     step_reg, step_next;
    logic [DIG_CNT_W-1:0] dig_reg, dig_next;

    logic [DIGIT_W-1:0]   digit;
    logic [PROD_W-1:0]    digit_prod;
    logic [DEN_W:0]       rem_shift;
    logic [DEN_W+1:0]     diff;
    logic [NUM_W-1:0]     elapsed_ext;

    // Partial product of one travel time digit with the microsecond scale.
    assign digit      = travel_reg[TRAVEL_W-1 -: DIGIT_W];
    assign digit_prod = PROD_W'(digit) * PROD_W'(US_PER_SEC);

    // Trial subtraction of one restoring division step.
    assign rem_shift  = {rem_reg, num_reg[NUM_W-1]};
    assign diff       = {1'b0, rem_shift} - {2'b00, den_reg};

    assign elapsed_ext = NUM_W'(elapsed);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        num_next    = num_reg;
        travel_next = travel_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        sat_next    = sat_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        dig_next    = dig_reg;

        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    // 100 = 64 + 32 + 4
                    num_next    = (elapsed_ext << 6) + (elapsed_ext << 5)
                                + (elapsed_ext << 2);
                    travel_next = travel;
                    den_next    = '0;
                    dig_next    = '0;
                    state_next  = D_DEN;
                end
            end
            D_DEN:
            begin
                den_next    = (den_reg << DIGIT_W) + DEN_W'(digit_prod);
                travel_next = travel_reg << DIGIT_W;
                dig_next    = dig_reg + 1'b1;
                if (dig_reg == DIG_CNT_W'(DEN_DIGITS - 1))
                begin
                    rem_next   = '0;
                    q_next     = '0;
                    sat_next   = 1'b0;
                    step_next  = '0;
                    state_next = D_DIV;
                end
            end
            D_DIV:
            begin
                // Zeros shift in behind the numerator: the 2^F scaling.
                num_next = num_reg << 1;
                if (!diff[DEN_W+1])
                begin
                    rem_next = diff[DEN_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[DEN_W-1:0];
                end
                q_next    = {q_reg[QW-2:0], ~diff[DEN_W+1]};
                sat_next  = sat_reg | q_reg[QW-1];
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            dig_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
            dig_reg   <= dig_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        travel_reg <= travel_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        sat_reg    <= sat_next;
    end

    assign quotient       = q_reg;
    assign stat.done      = done_reg;
    assign stat.saturated = sat_reg;

endmodule

[hw/rtl/timed_travel_position_tracker.sv]
// ----------------------------------------------------------------------------
// timed_travel_position_tracker
// Dead-reckoning position of a blind from motor run time. Keeps the motion
// mode and a fixed-point percent position, advancing it on every request but
// set position by the time elapsed while moving.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+----------------------------------
//   item     | item_valid / item_stall      | req_type, elapsed_us, new_position
//   result   | result_valid / result_stall  | position_out, motion_out, is_moving
//   config   | cfg_we                       | cfg_wdata (travel time, seconds)
//
// A transaction that advances the position presents its result after the
// divider scales the travel time digit by digit, runs one restoring division
// step per dividend bit and hands over the quotient, and the result is then
// registered. Other transactions pass through the apply state and register
// their result there once the result register is free. One transaction is in
// flight at a time; the result register lets the next one be accepted while a
// result waits. A stalled result holds the final update until the result
// register frees up. Reset clears the position to closed, the mode to idle and
// the travel time to 30 seconds.
// ----------------------------------------------------------------------------
module timed_travel_position_tracker
    import ttpt_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // item channel
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [ELAPSED_W-1:0]   elapsed_us,
    input  logic [POS_W-1:0]       new_position,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [POS_W-1:0]       position_out,
    output logic [1:0]             motion_out,
    output logic                   is_moving,
    // configuration
    input  logic                   cfg_we,
    input  logic [TRAVEL_W-1:0]    cfg_wdata
);

    localparam int QW = FRACTION_BITS + 7;
    localparam int CW = (QW > POS_W) ? QW : POS_W;
    localparam logic [QW-1:0] POS_FULL   = QW'(100) << FRACTION_BITS;
    localparam logic [QW-1:0] POS_HALF   = QW'(1) << (FRACTION_BITS - 1);
    localparam logic [QW-1:0] POS_MARGIN = QW'(199) << (FRACTION_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WAIT  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [TRAVEL_W-1:0]  travel_reg;
    logic [QW-1:0]        pos_reg, pos_next;
    mode_t                mode_reg, mode_next;
    logic [REQ_W-1:0]     req_reg;
    logic [POS_W-1:0]     newpos_reg;
    logic                 adv_reg, adv_next;
    logic                 result_valid_reg;
    logic [POS_W-1:0]     position_out_reg;
    logic [1:0]           motion_out_reg;
    logic                 is_moving_reg;

    logic                 item_accept;
    logic                 out_free;
    logic                 apply_fire;
    logic                 div_start;
    logic [QW-1:0]        div_q;
    div_stat_t            div_stat;

    logic [QW-1:0]        room;
    logic [QW-1:0]        adv_pos;
    mode_t                adv_mode;
    logic [CW-1:0]        newpos_ext;
    logic [CW-1:0]        pos_ext;

    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign apply_fire  = (state_reg == S_APPLY) && out_free;
    assign div_start   = item_accept && (req_type != REQ_SET)
                         && (mode_reg != MODE_IDLE) && (travel_reg != '0);
    assign item_stall  = (state_reg != S_IDLE);

    // Travel step divider.
    ttpt_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .elapsed  (elapsed_us),
        .travel   (travel_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Transaction sequencing.
    always_comb
    begin
        state_next = state_reg;
        adv_next   = adv_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    adv_next   = div_start;
                    state_next = div_start ? S_WAIT : S_APPLY;
                end
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Position advance with saturation and end-of-travel snapping.
    always_comb
    begin
        room     = POS_FULL - pos_reg;
        adv_pos  = pos_reg;
        adv_mode = mode_reg;
        if (adv_reg)
        begin
            if (mode_reg == MODE_OPENING)
            begin
                adv_pos = (div_stat.saturated || div_q >= room) ? POS_FULL
                                                                : pos_reg + div_q;
                if (adv_pos >= POS_MARGIN)
                begin
                    adv_pos  = POS_FULL;
                    adv_mode = MODE_IDLE;
                end
            end
            else
            begin
                adv_pos = (div_stat.saturated || div_q >= pos_reg) ? '0
                                                                   : pos_reg - div_q;
                if (adv_pos <= POS_HALF)
                begin
                    adv_pos  = '0;
                    adv_mode = MODE_IDLE;
                end
            end
        end
    end

    // Request decode on top of the advanced state.
    always_comb
    begin
        newpos_ext = CW'(newpos_reg);
        pos_next   = adv_pos;
        mode_next  = adv_mode;
        priority if (req_reg == REQ_SET)
        begin
            pos_next  = (newpos_ext > CW'(POS_FULL)) ? POS_FULL : newpos_ext[QW-1:0];
            mode_next = mode_reg;
        end
        else if (req_reg == REQ_OPEN)
        begin
            mode_next = MODE_OPENING;
        end
        else if (req_reg == REQ_CLOSE)
        begin
            mode_next = MODE_CLOSING;
        end
        else if (req_reg == REQ_STOP)
        begin
            mode_next = MODE_IDLE;
        end
        else
        begin
            mode_next = adv_mode;
        end
        pos_ext = CW'(pos_next);
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            travel_reg       <= TRAVEL_RESET;
            pos_reg          <= '0;
            mode_reg         <= MODE_IDLE;
            adv_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            adv_reg   <= adv_next;
            if (cfg_we)
            begin
                travel_reg <= cfg_wdata;
            end
            if (apply_fire)
            begin
                pos_reg  <= pos_next;
                mode_reg <= mode_next;
            end
            if (apply_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Captured request and result payload.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            req_reg    <= req_type;
            newpos_reg <= new_position;
        end
        if (apply_fire)
        begin
            position_out_reg <= pos_ext[POS_W-1:0];
            motion_out_reg   <= mode_next;
            is_moving_reg    <= (mode_next != MODE_IDLE);
        end
    end

    assign result_valid = result_valid_reg;
    assign position_out = position_out_reg;
    assign motion_out   = motion_out_reg;
    assign is_moving    = is_moving_reg;

    // The position never passes fully open.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("position beyond fully open");

    // The moving flag agrees with the reported mode.
    a_moving_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (is_moving_reg == (motion_out_reg != MODE_IDLE)))
        else $error("moving flag disagrees with motion mode");

    // A new result appears only from the final update step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result raised outside the update step");

    // The divider only reports completion while a transaction waits on it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_WAIT))
        else $error("divider finished with no transaction waiting");

endmodule
